@@ hw/rtl/qmg_pkg.sv @@
// Package: shared types and constants of the quadrature mouse generator.
package qmg_pkg;

    localparam logic [31:0] PATTERN_RESET = 32'h3333_3333;
    localparam int          DIV_BITS      = 16;
    localparam logic [15:0] SPEED_SCALE   = 16'd50000;
    localparam logic [15:0] MIN_PERIOD    = 16'd650;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_SPEED = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
    } t_item;

    // classified command: speed split into sign and magnitude
    typedef struct packed {
        t_kind       kind;
        logic        neg_x;
        logic [15:0] mag_x;
        logic        neg_y;
        logic [15:0] mag_y;
    } t_cmd;

    typedef struct packed {
        logic [31:0] x_pattern;
        logic [31:0] y_pattern;
    } t_result;

endpackage

@@ hw/rtl/qmg_in_if.sv @@
// Interface: input word channel (tick or set-speed).
interface qmg_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;

    modport source (output valid, output kind, output speed_x, output speed_y, input ready);
    modport sink   (input valid, input kind, input speed_x, input speed_y, output ready);
endinterface

@@ hw/rtl/qmg_out_if.sv @@
// Interface: output word channel (both axis patterns).
interface qmg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_pattern;
    logic [31:0] y_pattern;

    modport source (output valid, output x_pattern, output y_pattern, input ready);
    modport sink   (input valid, input x_pattern, input y_pattern, output ready);
endinterface

@@ hw/rtl/qmg_front.sv @@
// Front stage: accepts input words and classifies them into commands.
module qmg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qmg_pkg::t_item i_item,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output qmg_pkg::t_cmd  o_cmd
);

    logic          r_valid;
    qmg_pkg::t_cmd r_cmd;
    qmg_pkg::t_cmd n_cmd;
    logic [15:0]   ux;
    logic [15:0]   uy;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        ux          = i_item.speed_x;
        uy          = i_item.speed_y;
        n_cmd.kind  = i_item.kind;
        n_cmd.neg_x = ux[15];
        n_cmd.mag_x = ux[15] ? (~ux + 16'd1) : ux;
        n_cmd.neg_y = uy[15];
        n_cmd.mag_y = uy[15] ? (~uy + 16'd1) : uy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cmd <= n_cmd;
            end
        end
    end

endmodule

@@ hw/rtl/qmg_fifo.sv @@
// Short command queue between front and back stages.
module qmg_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  qmg_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output qmg_pkg::t_cmd o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qmg_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/qmg_div.sv @@
// Serial restoring divider: scale constant divided by a speed magnitude.
module qmg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    localparam int CNTW = $clog2(qmg_pkg::DIV_BITS);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [15:0]     r_rem;
    logic [15:0]     r_quo;
    logic [15:0]     r_dvs;
    logic [16:0]     rem_sh;
    logic            ge;
    logic [15:0]     n_rem;

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        rem_sh = {r_rem, r_quo[15]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? 16'(rem_sh - {1'b0, r_dvs}) : rem_sh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= qmg_pkg::SPEED_SCALE;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[14:0], ge};
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(qmg_pkg::DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/qmg_back.sv @@
// Back stage: axis state, tick stepping, period update and result register.
module qmg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    input  qmg_pkg::t_cmd    i_cmd,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output qmg_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY
    } t_state;

    typedef struct packed {
        logic [31:0] pattern;
        logic [15:0] elapsed;
    } t_axis;

    t_state           r_state;
    logic             r_out_valid;
    qmg_pkg::t_result r_res;
    logic [31:0]      r_pat_x;
    logic [31:0]      r_pat_y;
    logic             r_neg_x;
    logic             r_neg_y;
    logic [15:0]      r_mag_x;
    logic [15:0]      r_mag_y;
    logic [15:0]      r_el_x;
    logic [15:0]      r_el_y;
    qmg_pkg::t_cmd    r_cmd;

    logic             slot_free;
    logic             div_start;
    logic [15:0]      div_divisor;
    logic             div_done;
    logic [15:0]      div_quo;
    logic [15:0]      n_mag;
    t_axis            n_ax;
    t_axis            n_ay;

    function automatic t_axis tick_axis(input logic [31:0] pat, input logic neg,
                                        input logic [15:0] mag, input logic [15:0] el);
        t_axis       a;
        logic [15:0] e;
        e         = (el == qmg_pkg::ELAPSED_MAX) ? el : el + 16'd1;
        a.pattern = pat;
        a.elapsed = e;
        if (mag != 16'd0 && e > mag) begin
            a.elapsed = '0;
            a.pattern = neg ? {pat[30:0], pat[31]} : {pat[0], pat[31:1]};
        end
        return a;
    endfunction

    qmg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign slot_free   = !r_out_valid || i_res_ready;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && slot_free;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n_ax  = tick_axis(r_pat_x, r_neg_x, r_mag_x, r_el_x);
        n_ay  = tick_axis(r_pat_y, r_neg_y, r_mag_y, r_el_y);
        n_mag = (div_quo < qmg_pkg::MIN_PERIOD) ? qmg_pkg::MIN_PERIOD : div_quo;
        div_start   = 1'b0;
        div_divisor = i_cmd.mag_x;
        if (o_cmd_pop && i_cmd.kind == qmg_pkg::KIND_SPEED) begin
            div_start = 1'b1;
        end else if (r_state == S_DIVX && div_done) begin
            div_start   = 1'b1;
            div_divisor = r_cmd.mag_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pat_x     <= qmg_pkg::PATTERN_RESET;
            r_pat_y     <= qmg_pkg::PATTERN_RESET;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_mag_x     <= '0;
            r_mag_y     <= '0;
            r_el_x      <= '0;
            r_el_y      <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.kind == qmg_pkg::KIND_SPEED) begin
                            r_cmd   <= i_cmd;
                            r_state <= S_DIVX;
                        end else begin
                            r_pat_x           <= n_ax.pattern;
                            r_el_x            <= n_ax.elapsed;
                            r_pat_y           <= n_ay.pattern;
                            r_el_y            <= n_ay.elapsed;
                            r_res.x_pattern   <= n_ax.pattern;
                            r_res.y_pattern   <= n_ay.pattern;
                            r_out_valid       <= 1'b1;
                        end
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_neg_x <= r_cmd.neg_x && (r_cmd.mag_x != 16'd0);
                        r_mag_x <= (r_cmd.mag_x == 16'd0) ? 16'd0 : n_mag;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_neg_y         <= r_cmd.neg_y && (r_cmd.mag_y != 16'd0);
                        r_mag_y         <= (r_cmd.mag_y == 16'd0) ? 16'd0 : n_mag;
                        r_res.x_pattern <= r_pat_x;
                        r_res.y_pattern <= r_pat_y;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVX || r_state == S_DIVY))
        else $error("divider finished outside a divide state");

    a_slot_empty_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result register occupied during period update");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mag_x == 16'd0 || r_mag_x >= qmg_pkg::MIN_PERIOD)
        && (r_mag_y == 16'd0 || r_mag_y >= qmg_pkg::MIN_PERIOD))
        else $error("period magnitude below minimum");
`endif

endmodule

@@ hw/rtl/quadrature_mouse_generator_core.sv @@
// Top level: two-axis quadrature mouse pattern generator.
//
//  channel  dir  words                        handshake
//  i_in     in   kind, speed_x, speed_y       valid/ready
//  o_out    out  x_pattern, y_pattern         valid/ready
//
// A tick word passes the front register and the queue, then goes from the idle
// state of the back stage straight into the result register. A set-speed word runs
// two divisions in the back stage (start, 16 steps, done each), one after the other,
// on the shared serial divider.
// Reset is synchronous and clears all control state; patterns load 0x33333333.
// The queue lets the front keep taking words while the back divides or while
// the result register waits on o_out.ready.
module quadrature_mouse_generator_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qmg_in_if.sink           i_in,
    qmg_out_if.source        o_out
);

    qmg_pkg::t_item   item;
    qmg_pkg::t_cmd    f_cmd;
    logic             f_valid;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    qmg_pkg::t_cmd    q_cmd;
    qmg_pkg::t_result res;

    always_comb begin
        item.kind    = qmg_pkg::t_kind'(i_in.kind);
        item.speed_x = i_in.speed_x;
        item.speed_y = i_in.speed_y;
    end

    qmg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_item      (item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (!q_full),
        .o_cmd       (f_cmd)
    );

    qmg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_full  (q_full),
        .i_data  (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    qmg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    assign o_out.x_pattern = res.x_pattern;
    assign o_out.y_pattern = res.y_pattern;

endmodule

@@ sim/tb_quadrature_mouse_generator_core.sv @@
// Testbench: quadrature_mouse_generator_core checked word by word against a behavioral predictor.
module tb_quadrature_mouse_generator_core;

    localparam int LIMIT_CYCLES = 300_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_WORDS = 330;
    localparam int LONG_TICKS   = 702;
    localparam int TAIL_TICKS   = 100;
    localparam int HOLD_AT      = 1_200;
    localparam int HOLD_CYCLES  = 500;
    localparam int NUM_DIR      = 17;

    typedef struct packed {
        qmg_pkg::t_kind     kind;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        bit                 typed;
        logic [31:0]        x_pattern;
        logic [31:0]        y_pattern;
    } t_dir_row;

    localparam logic [31:0] PR = qmg_pkg::PATTERN_RESET;

    // typed rows: no axis can step within this many ticks
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{qmg_pkg::KIND_TICK,  16'sd0,      16'sd0,      1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sd32767,  16'sh8000,   1'b1, PR, PR},
        '{qmg_pkg::KIND_TICK,  16'shFFFF,   16'shFFFF,   1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sd1,      -16'sd1,     1'b1, PR, PR},
        '{qmg_pkg::KIND_TICK,  16'sh5555,   16'shAAAA,   1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sd0,      16'sd0,      1'b1, PR, PR},
        '{qmg_pkg::KIND_TICK,  16'sd0,      16'sd0,      1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sd77,     -16'sd77,    1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sd76,     -16'sd76,    1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sh8000,   16'sd32767,  1'b1, PR, PR},
        '{qmg_pkg::KIND_TICK,  16'sd0,      16'sd0,      1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, -16'sd1,     16'sd1,      1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'sh5555,   16'shAAAA,   1'b1, PR, PR},
        '{qmg_pkg::KIND_SPEED, 16'shAAAA,   16'sh5555,   1'b1, PR, PR},
        '{qmg_pkg::KIND_TICK,  16'sd0,      16'sd0,      1'b0, '0, '0},
        '{qmg_pkg::KIND_SPEED, 16'sd0,      16'sd100,    1'b0, '0, '0},
        '{qmg_pkg::KIND_TICK,  16'sh7FFF,   16'sh8000,   1'b0, '0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    qmg_in_if  in_if ();
    qmg_out_if out_if ();

    quadrature_mouse_generator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [31:0] x_pat, y_pat;
    int          x_period, y_period;
    logic [15:0] x_elapsed, y_elapsed;
    int          x_steps, y_steps, speed_words, words_sent;
    bit          saturated_seen;

    qmg_pkg::t_result pattern_q [$];
    int          src_idle_pct, snk_idle_pct;
    int          results_seen, errors, hold_left, cycles;
    bit          hold_done;

    function automatic int step_period(input logic signed [15:0] speed);
        int s;
        int p;
        int min_p;
        s     = int'(speed);
        min_p = int'(qmg_pkg::MIN_PERIOD);
        if (s == 0) return 0;
        p = int'(qmg_pkg::SPEED_SCALE) / s;
        if (s > 0 && p < min_p) p = min_p;
        else if (s < 0 && p > -min_p) p = -min_p;
        return p;
    endfunction

    function automatic bit step_axis(inout logic [31:0] pat, input int period,
                                     inout logic [15:0] elapsed);
        int mag;
        if (elapsed != qmg_pkg::ELAPSED_MAX) elapsed = elapsed + 16'd1;
        if (period == 0) return 1'b0;
        mag = (period < 0) ? -period : period;
        if (int'(elapsed) > mag) begin
            pat     = (period > 0) ? {pat[0], pat[31:1]} : {pat[30:0], pat[31]};
            elapsed = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic qmg_pkg::t_result predict_word(input qmg_pkg::t_kind kind,
                                                      input logic signed [15:0] sx, sy);
        qmg_pkg::t_result r;
        if (kind == qmg_pkg::KIND_SPEED) begin
            x_period    = step_period(sx);
            y_period    = step_period(sy);
            speed_words = speed_words + 1;
        end else begin
            x_steps = x_steps + int'(step_axis(x_pat, x_period, x_elapsed));
            y_steps = y_steps + int'(step_axis(y_pat, y_period, y_elapsed));
            if (x_elapsed == qmg_pkg::ELAPSED_MAX || y_elapsed == qmg_pkg::ELAPSED_MAX)
                saturated_seen = 1'b1;
        end
        r.x_pattern = x_pat;
        r.y_pattern = y_pat;
        return r;
    endfunction

    task automatic send_word(input qmg_pkg::t_kind kind, input logic signed [15:0] sx, sy,
                             input bit typed, input logic [31:0] tx, ty);
        qmg_pkg::t_result want;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.kind    <= kind;
        in_if.speed_x <= sx;
        in_if.speed_y <= sy;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        want = predict_word(kind, sx, sy);
        if (typed) begin
            want.x_pattern = tx;
            want.y_pattern = ty;
        end
        pattern_q.push_back(want);
        words_sent = words_sent + 1;
    endtask

    function automatic logic signed [15:0] pick_speed();
        logic signed [15:0] s;
        int                 mag;
        mag = 0;
        s   = '0;
        case ($urandom_range(9))
            0: s = 16'sd0;
            1: s = 16'sd32767;
            2: s = 16'sh8000;
            3, 4: mag = $urandom_range(200, 77);
            5: mag = $urandom_range(76, 60);
            6: mag = $urandom_range(59, 1);
            8, 9: mag = $urandom_range(32767, 77);
            default: s = 16'($urandom);
        endcase
        if (mag != 0) begin
            s = 16'(mag);
            if ($urandom_range(1)) s = -s;
        end
        return s;
    endfunction

    task automatic send_tick();
        logic signed [15:0] jx, jy;
        jx = 16'($urandom);
        jy = 16'($urandom);
        send_word(qmg_pkg::KIND_TICK, jx, jy, 1'b0, '0, '0);
    endtask

    task automatic send_random_word();
        logic signed [15:0] sx, sy;
        if ($urandom_range(99) < 4) begin
            sx = pick_speed();
            sy = pick_speed();
            send_word(qmg_pkg::KIND_SPEED, sx, sy, 1'b0, '0, '0);
        end else begin
            send_tick();
        end
    endtask

    task automatic check_result(input logic [31:0] got_x, got_y);
        qmg_pkg::t_result want;
        results_seen = results_seen + 1;
        if (pattern_q.size() == 0) begin
            errors = errors + 1;
            if (errors <= 10)
                $display("unexpected word: x=%h y=%h", got_x, got_y);
        end else begin
            want = pattern_q.pop_front();
            if (got_x !== want.x_pattern || got_y !== want.y_pattern) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("word %0d: x exp %h got %h, y exp %h got %h", results_seen,
                             want.x_pattern, got_x, want.y_pattern, got_y);
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off
    initial out_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_result(out_if.x_pattern, out_if.y_pattern);
            if (hold_left != 0) begin
                hold_left    = hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("quadrature_mouse_generator_core: mismatch");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.kind     = qmg_pkg::KIND_TICK;
        in_if.speed_x  = '0;
        in_if.speed_y  = '0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        results_seen   = 0;
        errors         = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        cycles         = 0;
        x_pat          = qmg_pkg::PATTERN_RESET;
        y_pat          = qmg_pkg::PATTERN_RESET;
        x_period       = 0;
        y_period       = 0;
        x_elapsed      = '0;
        y_elapsed      = '0;
        x_steps        = 0;
        y_steps        = 0;
        speed_words    = 0;
        words_sent     = 0;
        saturated_seen = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_DIR; k++)
            send_word(DIR_ROWS[k].kind, DIR_ROWS[k].speed_x, DIR_ROWS[k].speed_y,
                      DIR_ROWS[k].typed, DIR_ROWS[k].x_pattern, DIR_ROWS[k].y_pattern);

        src_idle_pct = 27;
        snk_idle_pct <= 81;
        repeat (RANDOM_WORDS) send_random_word();

        src_idle_pct = 81;
        snk_idle_pct <= 27;
        repeat (RANDOM_WORDS) send_random_word();

        src_idle_pct = 0;
        snk_idle_pct <= 0;
        // X at the fastest rate while Y sits stopped and keeps counting
        send_word(qmg_pkg::KIND_SPEED, 16'sd100, 16'sd0, 1'b0, '0, '0);
        repeat (LONG_TICKS) send_tick();
        // Y has waited past the minimum period and steps on the first tick after restart
        send_word(qmg_pkg::KIND_SPEED, 16'sd0, 16'sh8000, 1'b0, '0, '0);
        repeat (TAIL_TICKS) send_tick();
        repeat (RANDOM_WORDS) send_random_word();
        in_if.valid <= 1'b0;

        while (pattern_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words (%0d set-speed), %0d X steps, %0d Y steps, saturation %s",
                 words_sent, speed_words, x_steps, y_steps, saturated_seen ? "hit" : "missed");
        $display("%0d words checked, %0d errors, %0d left over",
                 results_seen, errors, pattern_q.size());
        if (errors == 0 && pattern_q.size() == 0) begin
            $display("quadrature_mouse_generator_core: match");
        end else begin
            $display("quadrature_mouse_generator_core: mismatch");
        end
        $finish;
    end

endmodule
